FILE: rtl/multi_click_detector_assert.svh
// Assertion macros for the multi-click detector.
`ifndef MULTI_CLICK_DETECTOR_ASSERT_SVH
`define MULTI_CLICK_DETECTOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked on the rising clock edge outside reset.
`define MCD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("multi_click_detector: same-cycle check failed");
// Next-cycle implication, checked on the rising clock edge outside reset.
`define MCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("multi_click_detector: next-cycle check failed");
`else
`define MCD_ASSERT_NOW(label, clk, rstn, ante, cons)
`define MCD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/mcd_pkg.sv
// Types, constants and phase-machine function for the multi-click detector.
package mcd_pkg;

    localparam int TIME_BITS   = 32;
    localparam int COORD_BITS  = 16;
    localparam int WINDOW_BITS = 16;
    localparam int TOL_BITS    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIPLE_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAD_WINDOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_TOLERANCE = 2'd3;

    localparam logic [WINDOW_BITS-1:0] RST_DOUBLE_WINDOW  = 16'd500;
    localparam logic [WINDOW_BITS-1:0] RST_TRIPLE_WINDOW  = 16'd750;
    localparam logic [WINDOW_BITS-1:0] RST_QUAD_WINDOW    = 16'd1000;
    localparam logic [TOL_BITS-1:0]    RST_MOVE_TOLERANCE = 8'd1;

    // phase that waits for the last release
    localparam logic [2:0] FINAL_DOUBLE = 3'd3;
    localparam logic [2:0] FINAL_TRIPLE = 3'd5;
    localparam logic [2:0] FINAL_QUAD   = 3'd7;
    localparam logic [2:0] PHASE_IDLE   = 3'd0;
    localparam logic [2:0] PHASE_FIRST  = 3'd1;

    typedef logic [TIME_BITS-1:0]         time_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;

    // one memory word: all three machines of one button
    typedef struct packed {
        logic [1:0] d_phase;
        logic [2:0] t_phase;
        logic [2:0] q_phase;
        time_t      d_start;
        time_t      t_start;
        time_t      q_start;
        coord_t     d_ax;
        coord_t     d_ay;
        coord_t     t_ax;
        coord_t     t_ay;
        coord_t     q_ax;
        coord_t     q_ay;
    } entry_t;

    typedef struct packed {
        logic [2:0] phase;
        time_t      start;
        coord_t     ax;
        coord_t     ay;
        logic       hit;
    } mach_res_t;

    function automatic logic mcd_too_far(input coord_t a, input coord_t b,
                                         input logic [TOL_BITS-1:0] tol);
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] mag;
        d   = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        mag = d[COORD_BITS] ? (~d + (COORD_BITS+1)'(1)) : d;
        return mag > (COORD_BITS+1)'(tol);
    endfunction

    function automatic mach_res_t mcd_run(input logic [2:0] phase, input time_t start,
                                          input coord_t ax, input coord_t ay,
                                          input logic [2:0] final_phase,
                                          input logic [WINDOW_BITS-1:0] window,
                                          input logic down, input coord_t x,
                                          input coord_t y, input time_t now,
                                          input logic [TOL_BITS-1:0] tol);
        mach_res_t r;
        logic [2:0] p;
        time_t      win;
        r.start = start;
        r.ax    = ax;
        r.ay    = ay;
        r.hit   = 1'b0;
        win     = TIME_BITS'(window);
        p       = phase;
        if (p > final_phase) begin
            p = PHASE_IDLE;
        end else if (p == PHASE_IDLE) begin
            if (down) begin
                r.start = now;
                r.ax    = x;
                r.ay    = y;
                p       = PHASE_FIRST;
            end
        end else if (p == final_phase) begin
            if (!down) begin
                p     = PHASE_IDLE;
                r.hit = ((now - start) < win);
            end
        end else if (p[0]) begin
            if (!down) p = p + 3'd1;
        end else begin
            if (down) p = p + 3'd1;
        end
        if (((p != PHASE_IDLE) && ((now - r.start) > win)) ||
            mcd_too_far(x, r.ax, tol) || mcd_too_far(y, r.ay, tol)) begin
            p       = PHASE_IDLE;
            r.start = '0;
        end
        r.phase = p;
        return r;
    endfunction

endpackage

FILE: rtl/multi_click_detector.sv
// Multi-click detector top level: per-button click phase machines held in one state memory.
// An accepted request is held in the stage-1 registers, then loads the output register that drives m_tvalid.
// Throughput: one request per cycle unless m_tready stalls; stage 1 reads the state memory,
// stage 2 updates it, with a forward register covering back-to-back requests to the same button.
// s_tready follows m_tready combinationally through the output register's free check.
// Reset (aresetn low, synchronous) clears pipeline valids, the per-button valid bits
// (an unwritten button reads as all-zero idle state) and loads the window and tolerance defaults.
module multi_click_detector
    import mcd_pkg::*;
#(
    parameter int NUM_BUTTONS = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // sample stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [0] button_down, [16:1] pointer_x, [32:17] pointer_y, [64:33] now_ticks, rest zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] button_index
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    // click result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] double_click, [1] triple_click, [2] quad_click, rest zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // register write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int IDX_W  = (ADDR_W > IN_TUSER_W) ? ADDR_W : IN_TUSER_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [WINDOW_BITS-1:0] dbl_window_reg;
    logic [WINDOW_BITS-1:0] tri_window_reg;
    logic [WINDOW_BITS-1:0] quad_window_reg;
    logic [TOL_BITS-1:0]    tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbl_window_reg  <= RST_DOUBLE_WINDOW;
            tri_window_reg  <= RST_TRIPLE_WINDOW;
            quad_window_reg <= RST_QUAD_WINDOW;
            tol_reg         <= RST_MOVE_TOLERANCE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DOUBLE_WINDOW:  dbl_window_reg  <= cfg_data;
                REG_TRIPLE_WINDOW:  tri_window_reg  <= cfg_data;
                REG_QUAD_WINDOW:    quad_window_reg <= cfg_data;
                REG_MOVE_TOLERANCE: tol_reg         <= cfg_data[TOL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s_fire;
    logic s1_fire;

    // stage 2 moves whenever the output register is empty or being drained
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_fire   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // stage 1: decode request, read state memory
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  in_idx;
    logic [ADDR_W-1:0] in_addr;
    logic              in_range;

    assign in_idx   = IDX_W'(s_tuser);
    assign in_addr  = in_idx[ADDR_W-1:0];
    assign in_range = ({{(32-IN_TUSER_W){1'b0}}, s_tuser} < 32'(NUM_BUTTONS));

    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_in_range_reg;
    logic              s1_down_reg;
    coord_t            s1_x_reg;
    coord_t            s1_y_reg;
    time_t             s1_now_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_addr_reg     <= in_addr;
            s1_in_range_reg <= in_range;
            s1_down_reg     <= s_tdata[0];
            s1_x_reg        <= s_tdata[16:1];
            s1_y_reg        <= s_tdata[32:17];
            s1_now_reg      <= s_tdata[64:33];
        end
    end

    // state memory, read data registered; valid bits stand in for clearing
    entry_t                 state_mem_reg [NUM_BUTTONS];
    entry_t                 rd_entry_reg;
    logic                   rd_valid_reg;
    logic [NUM_BUTTONS-1:0] valid_reg;
    entry_t                 wr_entry;
    logic                   wr_en;

    always_ff @(posedge aclk) begin
        if (s_fire) rd_entry_reg <= state_mem_reg[in_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en) state_mem_reg[s1_addr_reg] <= wr_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[s1_addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) rd_valid_reg <= in_range && valid_reg[in_addr];
    end

    // forward: the item leaving stage 2 writes the entry the new item just read
    logic   fwd_valid_reg;
    entry_t fwd_entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (s_fire) begin
            fwd_valid_reg <= wr_en && (s1_addr_reg == in_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) fwd_entry_reg <= wr_entry;
    end

    // ------------------------------------------------------------------
    // stage 2: run the three machines, write back, load output
    // ------------------------------------------------------------------
    entry_t    cur_entry;
    mach_res_t res_d;
    mach_res_t res_t;
    mach_res_t res_q;
    logic [2:0] hits;

    always_comb begin
        if (fwd_valid_reg) cur_entry = fwd_entry_reg;
        else if (rd_valid_reg) cur_entry = rd_entry_reg;
        else cur_entry = '0;
    end

    assign res_d = mcd_run({1'b0, cur_entry.d_phase}, cur_entry.d_start, cur_entry.d_ax,
                           cur_entry.d_ay, FINAL_DOUBLE, dbl_window_reg, s1_down_reg,
                           s1_x_reg, s1_y_reg, s1_now_reg, tol_reg);
    assign res_t = mcd_run(cur_entry.t_phase, cur_entry.t_start, cur_entry.t_ax,
                           cur_entry.t_ay, FINAL_TRIPLE, tri_window_reg, s1_down_reg,
                           s1_x_reg, s1_y_reg, s1_now_reg, tol_reg);
    assign res_q = mcd_run(cur_entry.q_phase, cur_entry.q_start, cur_entry.q_ax,
                           cur_entry.q_ay, FINAL_QUAD, quad_window_reg, s1_down_reg,
                           s1_x_reg, s1_y_reg, s1_now_reg, tol_reg);

    always_comb begin
        wr_entry.d_phase = res_d.phase[1:0];
        wr_entry.t_phase = res_t.phase;
        wr_entry.q_phase = res_q.phase;
        wr_entry.d_start = res_d.start;
        wr_entry.t_start = res_t.start;
        wr_entry.q_start = res_q.start;
        wr_entry.d_ax    = res_d.ax;
        wr_entry.d_ay    = res_d.ay;
        wr_entry.t_ax    = res_t.ax;
        wr_entry.t_ay    = res_t.ay;
        wr_entry.q_ax    = res_q.ax;
        wr_entry.q_ay    = res_q.ay;
    end

    // a sample for a button index of NUM_BUTTONS or more leaves state alone and reports no clicks
    assign wr_en = s1_fire && s1_in_range_reg;
    assign hits  = s1_in_range_reg ? {res_q.hit, res_t.hit, res_d.hit} : 3'b000;

    logic [2:0] out_hits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) out_hits_reg <= hits;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-3){1'b0}}, out_hits_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`include "multi_click_detector_assert.svh"

    // a click only ever completes on a release sample
    `MCD_ASSERT_NOW(a_hit_on_release, aclk, aresetn, s1_fire && (hits != 3'b000), !s1_down_reg)
    // a stalled stage-2 item keeps its button and sample
    `MCD_ASSERT_NEXT(a_stall_holds, aclk, aresetn, s1_valid_reg && !s1_fire,
                     s1_valid_reg && $stable(s1_addr_reg) && $stable(s1_now_reg))
    // back-to-back requests to one button must pick up the forwarded state
    `MCD_ASSERT_NEXT(a_forward_taken, aclk, aresetn,
                     s_fire && wr_en && (s1_addr_reg == in_addr), fwd_valid_reg)

endmodule
